// ===== rtl/strict_priority_multi_ring_queue_macros.svh =====
// Assertion macros used by the back end of the strict priority ring queue RTL.
`ifndef STRICT_PRIORITY_MULTI_RING_QUEUE_MACROS_SVH
`define STRICT_PRIORITY_MULTI_RING_QUEUE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Check that cons holds in the cycle after ante.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and codes of the strict priority ring queue.
package spq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [2:0] COUNT_MAX = 3'd7;

  // depths of the command queue and the result queue
  localparam int CQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  // classified command word, payload travels beside it
  typedef struct packed {
    logic       op;
    logic       lvl_ok;
    logic [2:0] level;
    logic       batch_end;
    logic [2:0] count;
  } cmd_t;

  // result word without its payload
  typedef struct packed {
    logic [1:0] kind;
    logic       accepted;
    logic [2:0] added_count;
    logic [1:0] prio;
    logic       last;
  } res_t;

endpackage

// ===== rtl/spq_fifo.sv =====
// Small register FIFO used for the command and result queues.
module spq_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign count   = fill;
  assign dout    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/spq_front.sv =====
// Front end: classifies incoming words and queues them as commands.
module spq_front #(
  parameter int LEVELS        = 4,
  parameter int MAX_POP       = 4,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       push,
  output logic                                       full,
  input  logic                                       op,
  input  logic [2:0]                                 priority_req,
  input  logic [PAYLOAD_WIDTH-1:0]                   payload,
  input  logic                                       batch_end,
  input  logic [2:0]                                 pop_limit,
  input  logic                                       cmd_pop,
  output logic                                       cmd_empty,
  output logic [$bits(spq_pkg::cmd_t)+PAYLOAD_WIDTH-1:0] cmd_word
);
  import spq_pkg::*;

  localparam int CMDW = $bits(cmd_t) + PAYLOAD_WIDTH;

  cmd_t cmd;

  // classify: range check the level, clamp the pop count
  always_comb begin
    cmd           = '0;
    cmd.op        = op;
    cmd.lvl_ok    = (int'(priority_req) < LEVELS);
    cmd.level     = priority_req;
    cmd.batch_end = batch_end;
    cmd.count     = (int'(pop_limit) > MAX_POP) ? 3'(MAX_POP) : pop_limit;
  end

  spq_fifo #(
    .WIDTH (CMDW),
    .DEPTH (CQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({cmd, payload}),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_word),
    .empty (cmd_empty),
    .count ()
  );

endmodule

// ===== rtl/spq_back.sv =====
// Back end: ring indices, ring store and the enqueue/dequeue sequencer.
module spq_back #(
  parameter int RING_DEPTH    = 8,
  parameter int LEVELS        = 4,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           cmd_empty,
  input  logic [$bits(spq_pkg::cmd_t)+PAYLOAD_WIDTH-1:0] cmd_word,
  output logic                                           cmd_pop,
  input  logic [$clog2(spq_pkg::OQ_DEPTH+1)-1:0]         out_count,
  output logic                                           res_valid,
  output spq_pkg::res_t                                  res,
  output logic [PAYLOAD_WIDTH-1:0]                       res_payload
);
  import spq_pkg::*;
`include "strict_priority_multi_ring_queue_macros.svh"

  localparam int IW  = $clog2(RING_DEPTH);
  localparam int LW  = $clog2(LEVELS);
  localparam int AW  = $clog2(LEVELS * RING_DEPTH);
  localparam int OCW = $clog2(OQ_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DEQ  = 1'b1;

  logic [PAYLOAD_WIDTH-1:0] ring_mem [LEVELS * RING_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] rdata;

  logic [IW-1:0] rd_idx [LEVELS];
  logic [IW-1:0] wr_idx [LEVELS];

  logic          state, state_next;
  logic [LW-1:0] cur_lvl, cur_lvl_next;
  logic [2:0]    left, left_next;
  logic [2:0]    batch_cnt, batch_cnt_next;
  res_t          res_next;
  logic          issue;

  cmd_t                     cmd;
  logic [PAYLOAD_WIDTH-1:0] cmd_payload;
  logic [LEVELS-1:0]        nonempty;
  logic                     hit_found;
  logic [LW-1:0]            hit_lvl;
  logic [LW-1:0]            sel_lvl;
  logic [IW-1:0]            rd_sel, wr_sel, rd_nx, wr_nx;
  logic                     room;
  logic                     mem_we, mem_re, rd_we, wr_we;
  logic                     enq_ok;
  logic                     pop_last;
  logic [AW-1:0]            base_addr;

  assign cmd         = cmd_t'(cmd_word[$bits(cmd_t)+PAYLOAD_WIDTH-1 -: $bits(cmd_t)]);
  assign cmd_payload = cmd_word[PAYLOAD_WIDTH-1:0];

  // flag non-empty rings and pick the highest priority one
  always_comb begin
    hit_found = 1'b0;
    hit_lvl   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (rd_idx[i] != wr_idx[i]);
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        hit_found = 1'b1;
        hit_lvl   = LW'(i);
      end
    end
  end

  // select the ring under work and its wrapped indices
  assign sel_lvl   = (state == ST_DEQ) ? cur_lvl : LW'(cmd.level);
  assign rd_sel    = rd_idx[sel_lvl];
  assign wr_sel    = wr_idx[sel_lvl];
  assign rd_nx     = (rd_sel == IW'(RING_DEPTH - 1)) ? '0 : rd_sel + 1'b1;
  assign wr_nx     = (wr_sel == IW'(RING_DEPTH - 1)) ? '0 : wr_sel + 1'b1;
  assign base_addr = AW'(sel_lvl) * AW'(RING_DEPTH);
  assign enq_ok    = cmd.lvl_ok && (wr_nx != rd_sel);
  assign pop_last  = (left == 3'd1) || (rd_nx == wr_sel);

  // hold off unless the result queue keeps a slot for this word
  assign room = ({1'b0, out_count} + (OCW + 1)'(res_valid)) < (OCW + 1)'(OQ_DEPTH);

  // sequence commands: one word per cycle at most
  always_comb begin
    cmd_pop        = 1'b0;
    issue          = 1'b0;
    res_next       = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    rd_we          = 1'b0;
    wr_we          = 1'b0;
    state_next     = state;
    cur_lvl_next   = cur_lvl;
    left_next      = left;
    batch_cnt_next = batch_cnt;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty && room) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_ENQ) begin
            issue          = 1'b1;
            res_next.kind  = KIND_ACK;
            res_next.last  = 1'b1;
            res_next.accepted = enq_ok;
            if (enq_ok) begin
              mem_we = 1'b1;
              wr_we  = 1'b1;
            end
            res_next.added_count = (enq_ok && batch_cnt < COUNT_MAX) ?
                                   batch_cnt + 1'b1 : batch_cnt;
            batch_cnt_next = cmd.batch_end ? '0 : res_next.added_count;
          end else if (cmd.count == '0 || !hit_found) begin
            issue         = 1'b1;
            res_next.kind = KIND_NONE;
            res_next.last = 1'b1;
          end else begin
            state_next   = ST_DEQ;
            cur_lvl_next = hit_lvl;
            left_next    = cmd.count;
          end
        end
      end
      ST_DEQ: begin
        if (room) begin
          issue         = 1'b1;
          mem_re        = 1'b1;
          rd_we         = 1'b1;
          res_next.kind = KIND_POP;
          res_next.prio = 2'(cur_lvl);
          res_next.last = pop_last;
          left_next     = left - 1'b1;
          if (pop_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // write and read the ring store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[base_addr + AW'(wr_sel)] <= cmd_payload;
    end
    if (mem_re) begin
      rdata <= ring_mem[base_addr + AW'(rd_sel)];
    end
  end

  // advance control state and ring indices
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      batch_cnt <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        rd_idx[i] <= '0;
        wr_idx[i] <= '0;
      end
    end else begin
      state     <= state_next;
      res_valid <= issue;
      batch_cnt <= batch_cnt_next;
      if (rd_we) begin
        rd_idx[sel_lvl] <= rd_nx;
      end
      if (wr_we) begin
        wr_idx[sel_lvl] <= wr_nx;
      end
    end
  end

  // hold result fields beside the store read
  always_ff @(posedge clk) begin
    res     <= res_next;
    cur_lvl <= cur_lvl_next;
    left    <= left_next;
  end

  assign res_payload = (res.kind == KIND_POP) ? rdata : '0;

  `SPQ_ASSERT_SAME(a_res_has_slot, clk, rst, res_valid, out_count < OCW'(OQ_DEPTH))
  `SPQ_ASSERT_SAME(a_deq_ring_nonempty, clk, rst, state == ST_DEQ, nonempty[cur_lvl])
  `SPQ_ASSERT_NEXT(a_last_pop_idles, clk, rst, state == ST_DEQ && issue && pop_last,
                   state == ST_IDLE)
  `SPQ_ASSERT_SAME(a_no_cmd_in_deq, clk, rst, state == ST_DEQ, !cmd_pop)

endmodule

// ===== rtl/strict_priority_multi_ring_queue.sv =====
// Top level of the strict priority multi-ring queue.
//
// Input channel: a word is taken when push is high and full is low. op 0
// stores payload in the ring of priority_req (0 is highest) and answers with
// one ack; op 1 pops up to pop_limit entries, at most MAX_POP, from the highest
// priority ring that holds any, one result per entry, or a single "nothing" result.
// Result channel: the oldest result shows while empty is low and leaves when
// pop is high. last marks the final result caused by one input word.
// An enqueue or an empty dequeue is handled by the sequencer while idle; a
// dequeue that finds entries moves it to the dequeue state, where it pops them
// one at a time, as the ring store has a single read port, and takes no new
// word from the command queue until the last entry is popped.
// A two-entry command queue and a four-entry result queue sit between the
// channels and the sequencer; when pop stays low the result queue fills, the
// sequencer stops, then the command queue fills and full goes high.
// Reset empties both queues, all rings and the batch count; the ring store
// itself needs no clearing.
module strict_priority_multi_ring_queue #(
  parameter int RING_DEPTH    = 8,
  parameter int LEVELS        = 4,
  parameter int MAX_POP       = 4,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     op,
  input  logic [2:0]               priority_req,
  input  logic [PAYLOAD_WIDTH-1:0] payload,
  input  logic                     batch_end,
  input  logic [2:0]               pop_limit,
  output logic                     empty,
  input  logic                     pop,
  output logic [1:0]               kind,
  output logic                     accepted,
  output logic [2:0]               added_count,
  output logic [PAYLOAD_WIDTH-1:0] out_payload,
  output logic [1:0]               out_priority,
  output logic                     last
);
  import spq_pkg::*;

  localparam int CMDW = $bits(cmd_t) + PAYLOAD_WIDTH;
  localparam int RESW = $bits(res_t) + PAYLOAD_WIDTH;

  logic                           cmd_pop;
  logic                           cmd_empty;
  logic [CMDW-1:0]                cmd_word;
  logic [$clog2(OQ_DEPTH+1)-1:0]  out_count;
  logic                           res_valid;
  res_t                           res;
  logic [PAYLOAD_WIDTH-1:0]       res_payload;
  logic [RESW-1:0]                out_word;
  res_t                           out_res;

  spq_front #(
    .LEVELS        (LEVELS),
    .MAX_POP       (MAX_POP),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .priority_req (priority_req),
    .payload      (payload),
    .batch_end    (batch_end),
    .pop_limit    (pop_limit),
    .cmd_pop      (cmd_pop),
    .cmd_empty    (cmd_empty),
    .cmd_word     (cmd_word)
  );

  spq_back #(
    .RING_DEPTH    (RING_DEPTH),
    .LEVELS        (LEVELS),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (cmd_empty),
    .cmd_word    (cmd_word),
    .cmd_pop     (cmd_pop),
    .out_count   (out_count),
    .res_valid   (res_valid),
    .res         (res),
    .res_payload (res_payload)
  );

  spq_fifo #(
    .WIDTH (RESW),
    .DEPTH (OQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   ({res, res_payload}),
    .full  (),
    .pop   (pop),
    .dout  (out_word),
    .empty (empty),
    .count (out_count)
  );

  // unpack the oldest result word
  assign out_res      = res_t'(out_word[RESW-1 -: $bits(res_t)]);
  assign out_payload  = out_word[PAYLOAD_WIDTH-1:0];
  assign kind         = out_res.kind;
  assign accepted     = out_res.accepted;
  assign added_count  = out_res.added_count;
  assign out_priority = out_res.prio;
  assign last         = out_res.last;

endmodule

// ===== verif/strict_priority_multi_ring_queue_test.sv =====
// Self-checking testbench of the strict priority multi-ring queue.
module strict_priority_multi_ring_queue_test;
  import spq_pkg::*;

  localparam int RING_DEPTH  = 8;
  localparam int LEVELS      = 4;
  localparam int MAX_POP     = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // one result word as the block should present it
  typedef struct {
    logic [1:0]  kind;
    logic        accepted;
    logic [2:0]  added_count;
    logic [31:0] data;
    logic [1:0]  prio;
    logic        last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        op = OP_ENQ;
  logic [2:0]  priority_req = '0;
  logic [31:0] payload = '0;
  logic        batch_end = 1'b0;
  logic [2:0]  pop_limit = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic        accepted;
  logic [2:0]  added_count;
  logic [31:0] out_payload;
  logic [1:0]  out_priority;
  logic        last;

  // shadow copy of the rings and the batch count
  logic [31:0]  ring_data [LEVELS][RING_DEPTH];
  int           ring_rd [LEVELS];
  int           ring_wr [LEVELS];
  logic [2:0]   batch_cnt;
  result_word_t pending_results [$];

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int err_count = 0;
  int cycle_count = 0;

  strict_priority_multi_ring_queue dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .priority_req (priority_req),
    .payload      (payload),
    .batch_end    (batch_end),
    .pop_limit    (pop_limit),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .accepted     (accepted),
    .added_count  (added_count),
    .out_payload  (out_payload),
    .out_priority (out_priority),
    .last         (last)
  );

  always #5 clk = ~clk;

  // Work out the results one accepted word causes and update the shadow rings.
  task automatic queue_results(input logic o, input logic [2:0] pr, input logic [31:0] pl,
                               input logic be, input logic [2:0] mx);
    result_word_t r;
    int lv;
    int nx;
    int take;
    int avail;
    int l;
    logic ok;
    r = '{kind: KIND_ACK, accepted: 1'b0, added_count: 3'd0, data: 32'd0, prio: 2'd0,
          last: 1'b1};
    if (o == OP_ENQ) begin
      // store when the level exists and its ring has room
      ok = 1'b0;
      if (pr < LEVELS) begin
        lv = pr;
        nx = (ring_wr[lv] + 1) % RING_DEPTH;
        if (nx != ring_rd[lv]) begin
          ring_data[lv][ring_wr[lv]] = pl;
          ring_wr[lv] = nx;
          ok = 1'b1;
        end
      end
      if (ok && batch_cnt != COUNT_MAX) batch_cnt = batch_cnt + 3'd1;
      r.accepted = ok;
      r.added_count = batch_cnt;
      pending_results.push_back(r);
      if (be) batch_cnt = 3'd0;
    end else begin
      // pop from the highest priority ring that holds anything
      lv = -1;
      for (l = LEVELS - 1; l >= 0; l--) begin
        if (ring_rd[l] != ring_wr[l]) lv = l;
      end
      take = (mx > MAX_POP) ? MAX_POP : mx;
      avail = (lv < 0) ? 0 : (ring_wr[lv] - ring_rd[lv] + RING_DEPTH) % RING_DEPTH;
      if (avail < take) take = avail;
      if (take == 0) begin
        r.kind = KIND_NONE;
        pending_results.push_back(r);
      end else begin
        for (l = 0; l < take; l++) begin
          r.kind = KIND_POP;
          r.data = ring_data[lv][ring_rd[lv]];
          r.prio = lv[1:0];
          r.last = (l == take - 1);
          ring_rd[lv] = (ring_rd[lv] + 1) % RING_DEPTH;
          pending_results.push_back(r);
        end
      end
    end
  endtask

  // Offer one word after a random gap; leave push high once it is taken.
  task automatic send_word(input logic o, input logic [2:0] pr, input logic [31:0] pl,
                           input logic be, input logic [2:0] mx);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= o;
    priority_req <= pr;
    payload <= pl;
    batch_end <= be;
    pop_limit <= mx;
    do @(posedge clk); while (full);
    queue_results(o, pr, pl, be, mx);
  endtask

  task automatic send_enq(input logic [2:0] pr, input logic [31:0] pl, input logic be);
    send_word(OP_ENQ, pr, pl, be, 3'($urandom_range(7)));
  endtask

  task automatic send_deq(input logic [2:0] mx);
    send_word(OP_DEQ, 3'($urandom_range(7)), $urandom, 1'($urandom_range(1)), mx);
  endtask

  // Empty rings, zero pop limit, and out of range priorities.
  task automatic test_rejects_and_nothing();
    int p;
    send_deq(3'd4);
    for (p = 0; p < 8; p++) begin
      send_enq(p[2:0], (p % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF, 1'b0);
    end
    // a rejected word still ends its batch
    send_enq(3'd5, $urandom, 1'b1);
    send_deq(3'd0);
    send_deq(3'd7);
  endtask

  // Fill a ring to its limit and run the batch count into saturation.
  task automatic test_full_ring_and_saturation();
    int n;
    for (n = 0; n < 6; n++) send_enq(3'd3, $urandom, 1'b0);
    send_enq(3'd3, $urandom, 1'b0);
    send_enq(3'd2, $urandom, 1'b0);
    send_enq(3'd1, $urandom, 1'b1);
  endtask

  // Clamp large pop limits and drain rings in priority order.
  task automatic test_pop_limits();
    send_deq(3'd5);
    send_deq(3'd6);
    send_deq(3'd3);
    send_deq(3'd7);
  endtask

  // Mixed traffic with random content under the current idle settings.
  task automatic test_random_traffic(input int words, input int enq_pct);
    int n;
    int burst;
    logic [2:0] pr;
    for (n = 0; n < words; n++) begin
      if ($urandom_range(99) < 8) begin
        // hammer one ring until it overflows
        pr = 3'($urandom_range(3));
        for (burst = 0; burst < RING_DEPTH && n < words; burst++) begin
          send_enq(pr, $urandom, 1'($urandom_range(3) == 0));
          n++;
        end
      end else if ($urandom_range(99) < enq_pct) begin
        pr = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
        send_enq(pr, $urandom, 1'($urandom_range(3) == 0));
      end else begin
        send_deq(($urandom_range(99) < 85) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7)));
      end
    end
  endtask

  // Take results at random and compare each against the oldest expectation.
  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result: kind %0d payload %h last %0d",
                     kind, out_payload, last);
        end else begin
          want = pending_results.pop_front();
          if (kind !== want.kind || accepted !== want.accepted ||
              added_count !== want.added_count || out_payload !== want.data ||
              out_priority !== want.prio || last !== want.last) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("mismatch: want kind %0d acc %0d cnt %0d data %h prio %0d last %0d",
                       want.kind, want.accepted, want.added_count, want.data, want.prio,
                       want.last);
              $display("          got  kind %0d acc %0d cnt %0d data %h prio %0d last %0d",
                       kind, accepted, added_count, out_payload, out_priority, last);
            end
          end
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[strict_priority_multi_ring_queue] ERROR");
      $finish;
    end
  end

  initial begin
    int l;
    for (l = 0; l < LEVELS; l++) begin
      ring_rd[l] = 0;
      ring_wr[l] = 0;
    end
    batch_cnt = 3'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_rejects_and_nothing();
    test_full_ring_and_saturation();
    test_pop_limits();

    send_idle_pct = 0;
    pop_stall_pct = 0;
    test_random_traffic(112, 60);
    send_idle_pct = 59;
    pop_stall_pct = 0;
    test_random_traffic(112, 45);
    send_idle_pct = 0;
    pop_stall_pct = 59;
    test_random_traffic(112, 65);
    send_idle_pct = 7;
    pop_stall_pct = 7;
    test_random_traffic(112, 50);

    // let every expected word arrive, then watch for strays
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("[strict_priority_multi_ring_queue] OK");
    end else begin
      $display("[strict_priority_multi_ring_queue] ERROR");
    end
    $finish;
  end

endmodule
